// ----- rtl/fpa_pkg.sv -----
// Shared types, codes and the saturation helper of the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int FIELD_W        = 32;
   localparam int KIND_W         = 4;
   localparam int WIDE_W         = 72;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD      = 4'd0,
      KIND_SUB      = 4'd1,
      KIND_MUL      = 4'd2,
      KIND_DIV      = 4'd3,
      KIND_MIN      = 4'd4,
      KIND_MAX      = 4'd5,
      KIND_INC      = 4'd6,
      KIND_DEC      = 4'd7,
      KIND_FROM_INT = 4'd8,
      KIND_TO_INT   = 4'd9
   } kind_type;

   // Per-item control and partial results that ride along the pipeline
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] res;
      logic               ovf;
      logic               dbz;
      logic               less;
      logic               equal;
      logic               greater;
      logic               neg;
   } side_type;

   typedef struct packed {
      logic [FIELD_W-1:0] val;
      logic               ovf;
   } sat_type;

   // Clamp a wide signed value to a w-bit signed range, sign-extended to the field
   function automatic sat_type sat_to_width(input logic signed [WIDE_W-1:0] v,
                                            input int w);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      sat_type s;
      hi = (72'sd1 <<< (w - 1)) - 72'sd1;
      lo = -hi - 72'sd1;
      if (v > hi) begin
         s.val = hi[FIELD_W-1:0];
         s.ovf = 1'b1;
      end else if (v < lo) begin
         s.val = lo[FIELD_W-1:0];
         s.ovf = 1'b1;
      end else begin
         s.val = v[FIELD_W-1:0];
         s.ovf = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/fpa_req_if.sv -----
// Request channel: operation and two raw operands.
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output kind, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input kind, input operand_a, input operand_b,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/fpa_rsp_if.sv -----
// Response channel: result value and status flags.
`timescale 1ns / 1ps
`default_nettype none
interface fpa_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_value;
   logic        overflow;
   logic        divide_by_zero;
   logic        less;
   logic        equal;
   logic        greater;

   modport source (output valid, output result_value, output overflow,
                   output divide_by_zero, output less, output equal, output greater,
                   input ready);
   modport sink   (input valid, input result_value, input overflow,
                   input divide_by_zero, input less, input equal, input greater,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/fixed_point_alu_q24_8_top.sv -----
// Top level of the signed fixed-point ALU with a pipelined divider row.
// Fully pipelined: one item per cycle while the response side is ready. Every item passes
// a row of DATA_WIDTH + FRAC_BITS + 2 divider cells, one quotient bit each, as well as
// the setup stage, the product rounding stage and the output register. Each stage has
// its own valid bit, so empty stages fill up while the output waits. Rounding is half
// away from zero; overflowing results saturate.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8_top #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   fpa_req_if.sink   req_chan,
   fpa_rsp_if.source rsp_chan
);
   import fpa_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int NUM_W = DATA_WIDTH + FRAC_BITS + 2;

   logic              p_valid;
   logic              p_ready;
   side_type          p_side;
   logic [2*W-1:0]    p_prod;
   logic [NUM_W-1:0]  p_num;
   logic [W:0]        p_den;

   logic              c_valid [NUM_W+1];
   logic              c_ready [NUM_W+1];
   side_type          c_side  [NUM_W+1];
   logic [W:0]        c_rem   [NUM_W+1];
   logic [NUM_W-1:0]  c_shift [NUM_W+1];
   logic [W:0]        c_den   [NUM_W+1];

   fpa_prep #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_prep (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_chan.valid),
      .up_ready     (req_chan.ready),
      .up_kind      (req_chan.kind),
      .up_operand_a (req_chan.operand_a),
      .up_operand_b (req_chan.operand_b),
      .dn_valid     (p_valid),
      .dn_ready     (p_ready),
      .dn_side      (p_side),
      .dn_prod      (p_prod),
      .dn_num       (p_num),
      .dn_den       (p_den)
   );

   fpa_round #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_round (
      .clock    (clock),
      .reset    (reset),
      .up_valid (p_valid),
      .up_ready (p_ready),
      .up_side  (p_side),
      .up_prod  (p_prod),
      .up_num   (p_num),
      .up_den   (p_den),
      .dn_valid (c_valid[0]),
      .dn_ready (c_ready[0]),
      .dn_side  (c_side[0]),
      .dn_num   (c_shift[0]),
      .dn_den   (c_den[0])
   );

   // Start every division with an empty remainder
   assign c_rem[0] = '0;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      fpa_cell #(.DATA_WIDTH(W), .NUM_W(NUM_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c_valid[i]),
         .up_ready (c_ready[i]),
         .up_side  (c_side[i]),
         .up_rem   (c_rem[i]),
         .up_shift (c_shift[i]),
         .up_den   (c_den[i]),
         .dn_valid (c_valid[i+1]),
         .dn_ready (c_ready[i+1]),
         .dn_side  (c_side[i+1]),
         .dn_rem   (c_rem[i+1]),
         .dn_shift (c_shift[i+1]),
         .dn_den   (c_den[i+1])
      );
   end

   fpa_finish #(.DATA_WIDTH(W), .NUM_W(NUM_W)) u_finish (
      .clock             (clock),
      .reset             (reset),
      .up_valid          (c_valid[NUM_W]),
      .up_ready          (c_ready[NUM_W]),
      .up_side           (c_side[NUM_W]),
      .up_quot           (c_shift[NUM_W]),
      .dn_valid          (rsp_chan.valid),
      .dn_ready          (rsp_chan.ready),
      .dn_result_value   (rsp_chan.result_value),
      .dn_overflow       (rsp_chan.overflow),
      .dn_divide_by_zero (rsp_chan.divide_by_zero),
      .dn_less           (rsp_chan.less),
      .dn_equal          (rsp_chan.equal),
      .dn_greater        (rsp_chan.greater)
   );
endmodule
`default_nettype wire

// ----- rtl/fpa_prep.sv -----
// First stage: compare, simple operations, magnitude product and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module fpa_prep #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 8,
   parameter int NUM_W      = DATA_WIDTH + FRAC_BITS + 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       up_valid,
   output      logic                       up_ready,
   input  wire logic [3:0]                 up_kind,
   input  wire logic [31:0]                up_operand_a,
   input  wire logic [31:0]                up_operand_b,
   output      logic                       dn_valid,
   input  wire logic                       dn_ready,
   output      fpa_pkg::side_type          dn_side,
   output      logic [2*DATA_WIDTH-1:0]    dn_prod,
   output      logic [NUM_W-1:0]           dn_num,
   output      logic [DATA_WIDTH:0]        dn_den
);
   import fpa_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * DATA_WIDTH;

   logic signed [W-1:0] a_w;
   logic signed [W-1:0] b_w;
   logic signed [W-1:0] shr;
   logic [W-1:0]        mag_a;
   logic [W-1:0]        mag_b;
   logic [PW-1:0]       prod_c;
   side_type            side_c;
   sat_type             sat_c;

   logic                valid_ff;
   side_type            side_ff;
   logic [PW-1:0]       prod_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [W:0]          den_ff;

   assign a_w    = up_operand_a[W-1:0];
   assign b_w    = up_operand_b[W-1:0];
   assign shr    = a_w >>> FRAC_BITS;
   assign mag_a  = a_w[W-1] ? unsigned'(-a_w) : unsigned'(a_w);
   assign mag_b  = b_w[W-1] ? unsigned'(-b_w) : unsigned'(b_w);
   assign prod_c = PW'(mag_a) * PW'(mag_b);

   // Work out every operation that needs no long chain
   always_comb begin
      side_c         = '0;
      sat_c          = '0;
      side_c.kind    = up_kind;
      side_c.less    = a_w < b_w;
      side_c.equal   = a_w == b_w;
      side_c.greater = a_w > b_w;
      side_c.neg     = a_w[W-1] ^ b_w[W-1];
      unique case (kind_type'(up_kind))
         KIND_ADD:      sat_c = sat_to_width(WIDE_W'(a_w) + WIDE_W'(b_w), W);
         KIND_SUB:      sat_c = sat_to_width(WIDE_W'(a_w) - WIDE_W'(b_w), W);
         KIND_INC:      sat_c = sat_to_width(WIDE_W'(a_w) + 72'sd1, W);
         KIND_DEC:      sat_c = sat_to_width(WIDE_W'(a_w) - 72'sd1, W);
         KIND_FROM_INT: sat_c = sat_to_width(WIDE_W'(a_w) <<< FRAC_BITS, W);
         KIND_MIN:      sat_c.val = FIELD_W'(side_c.less ? a_w : b_w);
         KIND_MAX:      sat_c.val = FIELD_W'(side_c.greater ? a_w : b_w);
         KIND_TO_INT:   sat_c.val = FIELD_W'(shr);
         KIND_DIV:      side_c.dbz = (b_w == '0);
         default:       sat_c = '0;
      endcase
      side_c.res = sat_c.val;
      side_c.ovf = sat_c.ovf;
   end

   assign up_ready = !valid_ff || dn_ready;

   // Hold the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Load the payload on accept
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         side_ff <= side_c;
         prod_ff <= prod_c;
         num_ff  <= NUM_W'({mag_a, {FRAC_BITS{1'b0}}, 1'b0}) + NUM_W'(mag_b);
         den_ff  <= {mag_b, 1'b0};
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_prod  = prod_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
endmodule
`default_nettype wire

// ----- rtl/fpa_round.sv -----
// Second stage: round and saturate the product; pass divider setup along.
`timescale 1ns / 1ps
`default_nettype none
module fpa_round #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 8,
   parameter int NUM_W      = DATA_WIDTH + FRAC_BITS + 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   output      logic                     up_ready,
   input  wire fpa_pkg::side_type        up_side,
   input  wire logic [2*DATA_WIDTH-1:0]  up_prod,
   input  wire logic [NUM_W-1:0]         up_num,
   input  wire logic [DATA_WIDTH:0]      up_den,
   output      logic                     dn_valid,
   input  wire logic                     dn_ready,
   output      fpa_pkg::side_type        dn_side,
   output      logic [NUM_W-1:0]         dn_num,
   output      logic [DATA_WIDTH:0]      dn_den
);
   import fpa_pkg::*;

   localparam int PW = 2 * DATA_WIDTH;
   localparam logic [PW:0] Half = (PW + 1)'(1) << (FRAC_BITS - 1);

   logic [PW:0]              rsum;
   logic signed [WIDE_W-1:0] mag_x;
   sat_type                  sat_c;
   side_type                 side_c;

   logic                     valid_ff;
   side_type                 side_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DATA_WIDTH:0]      den_ff;

   // Round half away from zero on the magnitude, then apply the sign
   assign rsum  = {1'b0, up_prod} + Half;
   assign mag_x = signed'(WIDE_W'(rsum[PW:FRAC_BITS]));
   assign sat_c = sat_to_width(up_side.neg ? -mag_x : mag_x, DATA_WIDTH);

   always_comb begin
      side_c = up_side;
      if (kind_type'(up_side.kind) == KIND_MUL) begin
         side_c.res = sat_c.val;
         side_c.ovf = sat_c.ovf;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         side_ff <= side_c;
         num_ff  <= up_num;
         den_ff  <= up_den;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
endmodule
`default_nettype wire

// ----- rtl/fpa_cell.sv -----
// Divider cell: one restoring quotient bit per cell, registered.
`timescale 1ns / 1ps
`default_nettype none
module fpa_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int NUM_W      = 42
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output      logic                 up_ready,
   input  wire fpa_pkg::side_type    up_side,
   input  wire logic [DATA_WIDTH:0]  up_rem,
   input  wire logic [NUM_W-1:0]     up_shift,
   input  wire logic [DATA_WIDTH:0]  up_den,
   output      logic                 dn_valid,
   input  wire logic                 dn_ready,
   output      fpa_pkg::side_type    dn_side,
   output      logic [DATA_WIDTH:0]  dn_rem,
   output      logic [NUM_W-1:0]     dn_shift,
   output      logic [DATA_WIDTH:0]  dn_den
);
   import fpa_pkg::*;

   localparam int W = DATA_WIDTH;

   logic [W+1:0]     part;
   logic [W+1:0]     diff;
   logic             ge;

   logic             valid_ff;
   side_type         side_ff;
   logic [W:0]       rem_ff;
   logic [NUM_W-1:0] shift_ff;
   logic [W:0]       den_ff;

   // Bring down the next numerator bit and try the subtract
   assign part = {up_rem, up_shift[NUM_W-1]};
   assign diff = part - {1'b0, up_den};
   assign ge   = part >= {1'b0, up_den};

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Shift the quotient bit in where the numerator bit left
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         side_ff  <= up_side;
         rem_ff   <= ge ? diff[W:0] : part[W:0];
         shift_ff <= {up_shift[NUM_W-2:0], ge};
         den_ff   <= up_den;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_rem   = rem_ff;
   assign dn_shift = shift_ff;
   assign dn_den   = den_ff;
endmodule
`default_nettype wire

// ----- rtl/fpa_finish.sv -----
// Output stage: sign and saturate the quotient, hold the result item.
`timescale 1ns / 1ps
`default_nettype none
module fpa_finish #(
   parameter int DATA_WIDTH = 32,
   parameter int NUM_W      = 42
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output      logic              up_ready,
   input  wire fpa_pkg::side_type up_side,
   input  wire logic [NUM_W-1:0]  up_quot,
   output      logic              dn_valid,
   input  wire logic              dn_ready,
   output      logic [31:0]       dn_result_value,
   output      logic              dn_overflow,
   output      logic              dn_divide_by_zero,
   output      logic              dn_less,
   output      logic              dn_equal,
   output      logic              dn_greater
);
   import fpa_pkg::*;

   logic signed [WIDE_W-1:0] mag_x;
   sat_type                  sat_c;
   side_type                 side_c;

   logic                     valid_ff;
   side_type                 side_ff;

   assign mag_x = signed'(WIDE_W'(up_quot));
   assign sat_c = sat_to_width(up_side.neg ? -mag_x : mag_x, DATA_WIDTH);

   // Drop the quotient in for a division with a nonzero divisor
   always_comb begin
      side_c = up_side;
      if (kind_type'(up_side.kind) == KIND_DIV && !up_side.dbz) begin
         side_c.res = sat_c.val;
         side_c.ovf = sat_c.ovf;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         side_ff <= side_c;
      end
   end

   assign dn_valid          = valid_ff;
   assign dn_result_value   = side_ff.res;
   assign dn_overflow       = side_ff.ovf;
   assign dn_divide_by_zero = side_ff.dbz;
   assign dn_less           = side_ff.less;
   assign dn_equal          = side_ff.equal;
   assign dn_greater        = side_ff.greater;
endmodule
`default_nettype wire

// ----- rtl/fpa_check.sv -----
// Port-level checks of the fixed-point ALU and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpa_check #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic        rsp_overflow,
   input wire logic        rsp_divide_by_zero,
   input wire logic        rsp_less,
   input wire logic        rsp_equal,
   input wire logic        rsp_greater
);
   localparam logic signed [31:0] MaxVal = (32'sd1 <<< (DATA_WIDTH - 1)) - 32'sd1;
   localparam logic signed [31:0] MinVal = -MaxVal - 32'sd1;

   // A pending item stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Reset empties the pipeline
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item right after reset");

   // Exactly one compare outcome
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_less, rsp_equal, rsp_greater}))
      else $error("compare flags not exclusive");

   // Division by zero gives zero without overflow
   a_dbz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_value == '0 && !rsp_overflow)
      else $error("divide by zero result wrong");

   // Saturated results sit on a range limit
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_result_value == MaxVal || rsp_result_value == MinVal)
      else $error("overflow without saturation");
endmodule

bind fixed_point_alu_q24_8_top fpa_check #(.DATA_WIDTH(DATA_WIDTH)) u_fpa_check (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_result_value   (rsp_chan.result_value),
   .rsp_overflow       (rsp_chan.overflow),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero),
   .rsp_less           (rsp_chan.less),
   .rsp_equal          (rsp_chan.equal),
   .rsp_greater        (rsp_chan.greater)
);
`default_nettype wire

// ----- tb/fixed_point_alu_q24_8_checker.sv -----
// Checker for the fixed-point ALU: computes the expected result of each item and compares.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_checker (
   input  logic       clock,
   input  logic       reset,
   fpa_req_if         req_chan,
   fpa_rsp_if         rsp_chan,
   output int         fail_count,
   output int         pending_count,
   output int         result_count
);
   import fpa_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;

   typedef struct {
      logic [31:0] value;
      logic        ovf;
      logic        dbz;
      logic        lt;
      logic        eq;
      logic        gt;
   } alu_result_type;

   alu_result_type expected_results[$];
   int             mismatch_count;

   // Clamp to the signed 32-bit range and flag saturation
   function automatic longint clamp32(input longint v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Compute the exact result of one operation
   function automatic alu_result_type compute_alu(input logic [3:0] kind,
                                                  input logic signed [31:0] opa,
                                                  input logic signed [31:0] opb);
      alu_result_type res;
      longint      a;
      longint      b;
      longint      r;
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] den;
      logic        ovf;
      logic        neg;
      a   = opa;
      b   = opb;
      r   = 0;
      ovf = 1'b0;
      neg = (a < 0) != (b < 0);
      res.dbz = 1'b0;
      case (kind)
         KIND_ADD: r = clamp32(a + b, ovf);
         KIND_SUB: r = clamp32(a - b, ovf);
         KIND_MUL: begin
            mag = 64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b);
            quo = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
            r   = clamp32(neg ? -longint'(quo) : longint'(quo), ovf);
         end
         KIND_DIV: begin
            if (b == 0) begin
               res.dbz = 1'b1;
            end else begin
               mag = 64'(a < 0 ? -a : a) << FRAC;
               den = 64'(b < 0 ? -b : b);
               quo = (2 * mag + den) / (2 * den);
               r   = clamp32(neg ? -longint'(quo) : longint'(quo), ovf);
            end
         end
         KIND_MIN: r = (a < b) ? a : b;
         KIND_MAX: r = (a > b) ? a : b;
         KIND_INC: r = clamp32(a + 1, ovf);
         KIND_DEC: r = clamp32(a - 1, ovf);
         KIND_FROM_INT: r = clamp32(a * (64'sd1 <<< FRAC), ovf);
         KIND_TO_INT: r = a >>> FRAC;
         default: r = 0;
      endcase
      res.value = r[31:0];
      res.ovf   = ovf;
      res.lt    = a < b;
      res.eq    = a == b;
      res.gt    = a > b;
      return res;
   endfunction

   // Queue an expectation per accepted request, compare per accepted response
   always @(posedge clock) begin
      alu_result_type want;
      if (reset) begin
         fail_count     <= 0;
         mismatch_count = 0;
         result_count   <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(compute_alu(req_chan.kind, req_chan.operand_a,
                                                   req_chan.operand_b));
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               fail_count <= fail_count + 1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: result with no item outstanding at %0t", $realtime);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.result_value !== want.value || rsp_chan.overflow !== want.ovf ||
                   rsp_chan.divide_by_zero !== want.dbz || rsp_chan.less !== want.lt ||
                   rsp_chan.equal !== want.eq || rsp_chan.greater !== want.gt) begin
                  fail_count <= fail_count + 1;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"ERROR: exp val=%h ovf=%b dbz=%b lt/eq/gt=%b%b%b, ",
                               "got val=%h ovf=%b dbz=%b lt/eq/gt=%b%b%b"},
                              want.value, want.ovf, want.dbz, want.lt, want.eq, want.gt,
                              rsp_chan.result_value, rsp_chan.overflow,
                              rsp_chan.divide_by_zero, rsp_chan.less, rsp_chan.equal,
                              rsp_chan.greater);
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end
endmodule

// ----- tb/fixed_point_alu_q24_8_top_tb.sv -----
// Testbench top for the fixed-point ALU: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_top_tb;
   import fpa_pkg::*;

   localparam int RANDOM_ITEMS = 1030;
   localparam int DRAIN_CYCLES = 60;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   result_count;
   int   sent_count;
   logic stall_on;

   fpa_req_if req_chan ();
   fpa_rsp_if rsp_chan ();

   fixed_point_alu_q24_8_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fixed_point_alu_q24_8_checker alu_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side on a slowly changing duty pattern
   initial begin
      int mode;
      rsp_chan.ready = 1'b0;
      stall_on       = 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= stall_on ? $urandom_range(0, 1) : 1'b1;
         endcase
      end
   end

   // Interesting operand values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'h100;
         4: return 32'hFFFF_FF00;
         5: return 32'(int'($urandom_range(0, 4095)) - 2048);
         6: return 32'(int'($urandom_range(0, 65535)) - 32768);
         7: return {{9{$urandom_range(0, 1) == 1}}, 23'($urandom)};
         8: return 32'h80;
         default: return $urandom;
      endcase
   endfunction

   // Present one item and hold it until accepted
   task automatic send_item(input logic [3:0] kind, input logic [31:0] opa,
                            input logic [31:0] opb);
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.operand_a <= opa;
      req_chan.operand_b <= opb;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_cycles(input int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int         burst;
      logic [3:0] kind;
      logic [31:0] opb;
      sent_count         = 0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_ADD;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every operation, rounding ties, divide by zero, unused kinds
      send_item(KIND_ADD, 32'h7FFF_FFFF, 32'h1);
      send_item(KIND_ADD, 32'h8000_0000, 32'h8000_0000);
      send_item(KIND_SUB, 32'h8000_0000, 32'h1);
      send_item(KIND_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
      send_item(KIND_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      send_item(KIND_MUL, 32'h0000_0001, 32'h0000_0080);
      send_item(KIND_DIV, 32'h0000_0100, 32'h0);
      send_item(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(KIND_DIV, 32'h7FFF_FFFF, 32'h1);
      send_item(KIND_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
      send_item(KIND_DIV, 32'h0000_0001, 32'h0000_0003);
      send_item(KIND_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(KIND_MAX, 32'h1234, 32'h1234);
      send_item(KIND_INC, 32'h7FFF_FFFF, 32'h0);
      send_item(KIND_DEC, 32'h8000_0000, 32'h0);
      send_item(KIND_FROM_INT, 32'h0080_0000, 32'h0);
      send_item(KIND_FROM_INT, 32'hFF80_0000, 32'h0);
      send_item(KIND_FROM_INT, 32'hFF7F_FFFF, 32'h0);
      send_item(KIND_TO_INT, 32'hFFFF_FFFF, 32'h0);
      send_item(KIND_TO_INT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(4'd10, 32'h5, 32'h3);
      send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Let the pipeline drain completely before the random part
      idle_cycles(1);
      while (pending_count != 0) @(posedge clock);

      // Random bursts, most of them separated by random gaps
      while (sent_count < RANDOM_ITEMS + 24) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            opb  = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
            send_item(kind, pick_operand(), $urandom_range(0, 7) == 0 ? $urandom : opb);
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
         if ($urandom_range(0, 9) == 0) stall_on <= ~stall_on;
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d items over all operations, with saturation, rounding ties,",
               sent_count);
      $display("zero divisors and unused codes; %0d results checked.", result_count);
      if (fail_count == 0) begin
         $display("PASS fixed_point_alu_q24_8_top");
      end else begin
         $display("FAIL fixed_point_alu_q24_8_top");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("FAIL fixed_point_alu_q24_8_top");
      $finish;
   end
endmodule
